// File: rtl/rk4qfa_pkg.sv
// Package for the RK4 quadratic flow advector: widths, payload types, micro-program.
package rk4qfa_pkg;

  localparam int WORD_W = 32;
  localparam int FRAC_W = 24;
  localparam int STEP_COUNT_WIDTH_DEF = 16;

  localparam int STEP_COUNT_RST = 2000;
  localparam int STEP_SIZE_RST = 167772;
  localparam int COEFF_A_RST = -8388608;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEFF_A = 2'd2;

  localparam logic [63:0] WORD_MAX_U = (64'd1 << (WORD_W - 1)) - 64'd1;
  localparam logic [63:0] HALF_RAW = 64'd1 << (FRAC_W - 1);
  localparam logic [63:0] SIXTH_RAW = ((64'd1 << FRAC_W) + 64'd3) / 64'd6;
  localparam logic [63:0] HALF_CLAMP = (HALF_RAW > WORD_MAX_U) ? WORD_MAX_U : HALF_RAW;
  localparam logic [63:0] SIXTH_CLAMP = (SIXTH_RAW > WORD_MAX_U) ? WORD_MAX_U : SIXTH_RAW;
  localparam logic signed [WORD_W-1:0] HALF_C = HALF_CLAMP[WORD_W-1:0];
  localparam logic signed [WORD_W-1:0] SIXTH_C = SIXTH_CLAMP[WORD_W-1:0];
  localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

  localparam int PC_W = 6;
  localparam logic [PC_W-1:0] LAST_PC = 6'd51;

  typedef struct packed {
    logic signed [WORD_W-1:0] x1_start;
    logic signed [WORD_W-1:0] x2_start;
  } in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] x1_end;
    logic signed [WORD_W-1:0] x2_end;
    logic                     saturated;
  } res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MULW,
    ST_DONE
  } st_e;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_NEG,
    OP_MUL
  } op_e;

  typedef enum logic [4:0] {
    SRC_X1, SRC_X2, SRC_E1, SRC_E2, SRC_F1, SRC_F2, SRC_T, SRC_S,
    SRC_K0, SRC_K1, SRC_K2, SRC_K3, SRC_K4, SRC_K5, SRC_K6, SRC_K7,
    SRC_HALF, SRC_SIXTH, SRC_DT, SRC_A
  } src_e;

  typedef struct packed {
    op_e  op;
    src_e a;
    src_e b;
    src_e dst;
  } uop_t;

  function automatic uop_t mk(input op_e o, input src_e a, input src_e b, input src_e d);
    uop_t u;
    u.op  = o;
    u.a   = a;
    u.b   = b;
    u.dst = d;
    return u;
  endfunction

  // One full RK4 step: four slope stages, then the weighted update of both coordinates.
  function automatic uop_t uop_at(input logic [PC_W-1:0] pc);
    uop_t u;
    case (pc)
      6'd0:  u = mk(OP_MUL, SRC_X1, SRC_X2, SRC_F1);
      6'd1:  u = mk(OP_MUL, SRC_A, SRC_X1, SRC_T);
      6'd2:  u = mk(OP_MUL, SRC_T, SRC_X1, SRC_T);
      6'd3:  u = mk(OP_NEG, SRC_X2, SRC_X2, SRC_F2);
      6'd4:  u = mk(OP_ADD, SRC_F2, SRC_T, SRC_F2);
      6'd5:  u = mk(OP_MUL, SRC_F1, SRC_DT, SRC_K0);
      6'd6:  u = mk(OP_MUL, SRC_F2, SRC_DT, SRC_K1);
      6'd7:  u = mk(OP_MUL, SRC_K0, SRC_HALF, SRC_T);
      6'd8:  u = mk(OP_ADD, SRC_X1, SRC_T, SRC_E1);
      6'd9:  u = mk(OP_MUL, SRC_K1, SRC_HALF, SRC_T);
      6'd10: u = mk(OP_ADD, SRC_X2, SRC_T, SRC_E2);
      6'd11: u = mk(OP_MUL, SRC_E1, SRC_E2, SRC_F1);
      6'd12: u = mk(OP_MUL, SRC_A, SRC_E1, SRC_T);
      6'd13: u = mk(OP_MUL, SRC_T, SRC_E1, SRC_T);
      6'd14: u = mk(OP_NEG, SRC_E2, SRC_E2, SRC_F2);
      6'd15: u = mk(OP_ADD, SRC_F2, SRC_T, SRC_F2);
      6'd16: u = mk(OP_MUL, SRC_F1, SRC_DT, SRC_K2);
      6'd17: u = mk(OP_MUL, SRC_F2, SRC_DT, SRC_K3);
      6'd18: u = mk(OP_MUL, SRC_K2, SRC_HALF, SRC_T);
      6'd19: u = mk(OP_ADD, SRC_X1, SRC_T, SRC_E1);
      6'd20: u = mk(OP_MUL, SRC_K3, SRC_HALF, SRC_T);
      6'd21: u = mk(OP_ADD, SRC_X2, SRC_T, SRC_E2);
      6'd22: u = mk(OP_MUL, SRC_E1, SRC_E2, SRC_F1);
      6'd23: u = mk(OP_MUL, SRC_A, SRC_E1, SRC_T);
      6'd24: u = mk(OP_MUL, SRC_T, SRC_E1, SRC_T);
      6'd25: u = mk(OP_NEG, SRC_E2, SRC_E2, SRC_F2);
      6'd26: u = mk(OP_ADD, SRC_F2, SRC_T, SRC_F2);
      6'd27: u = mk(OP_MUL, SRC_F1, SRC_DT, SRC_K4);
      6'd28: u = mk(OP_MUL, SRC_F2, SRC_DT, SRC_K5);
      6'd29: u = mk(OP_ADD, SRC_X1, SRC_K4, SRC_E1);
      6'd30: u = mk(OP_ADD, SRC_X2, SRC_K5, SRC_E2);
      6'd31: u = mk(OP_MUL, SRC_E1, SRC_E2, SRC_F1);
      6'd32: u = mk(OP_MUL, SRC_A, SRC_E1, SRC_T);
      6'd33: u = mk(OP_MUL, SRC_T, SRC_E1, SRC_T);
      6'd34: u = mk(OP_NEG, SRC_E2, SRC_E2, SRC_F2);
      6'd35: u = mk(OP_ADD, SRC_F2, SRC_T, SRC_F2);
      6'd36: u = mk(OP_MUL, SRC_F1, SRC_DT, SRC_K6);
      6'd37: u = mk(OP_MUL, SRC_F2, SRC_DT, SRC_K7);
      6'd38: u = mk(OP_ADD, SRC_K2, SRC_K2, SRC_S);
      6'd39: u = mk(OP_ADD, SRC_K0, SRC_S, SRC_S);
      6'd40: u = mk(OP_ADD, SRC_K4, SRC_K4, SRC_T);
      6'd41: u = mk(OP_ADD, SRC_S, SRC_T, SRC_S);
      6'd42: u = mk(OP_ADD, SRC_S, SRC_K6, SRC_S);
      6'd43: u = mk(OP_MUL, SRC_S, SRC_SIXTH, SRC_T);
      6'd44: u = mk(OP_ADD, SRC_X1, SRC_T, SRC_X1);
      6'd45: u = mk(OP_ADD, SRC_K3, SRC_K3, SRC_S);
      6'd46: u = mk(OP_ADD, SRC_K1, SRC_S, SRC_S);
      6'd47: u = mk(OP_ADD, SRC_K5, SRC_K5, SRC_T);
      6'd48: u = mk(OP_ADD, SRC_S, SRC_T, SRC_S);
      6'd49: u = mk(OP_ADD, SRC_S, SRC_K7, SRC_S);
      6'd50: u = mk(OP_MUL, SRC_S, SRC_SIXTH, SRC_T);
      6'd51: u = mk(OP_ADD, SRC_X2, SRC_T, SRC_X2);
      default: u = mk(OP_ADD, SRC_T, SRC_T, SRC_T);
    endcase
    return u;
  endfunction

endpackage

// File: rtl/rk4_quadratic_flow_advector.sv
// RK4 advector for dx1 = x1*x2, dx2 = -x2 + a*x1^2: micro-programmed shared fixed-point ALU.
// Each RK4 step runs 52 micro-ops on one shared multiplier and saturating adder:
// 26 multiplies (product in ST_EXEC, then round and clip in ST_MULW) and 26 adds and negates.
// A new request is taken only while idle; busy stays high until done_o ends.
// Reset: idle, control and config registers at their reset values; results cannot be stalled by the receiver.
module rk4_quadratic_flow_advector #(
  parameter int STEP_COUNT_WIDTH = rk4qfa_pkg::STEP_COUNT_WIDTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  rk4qfa_pkg::in_t                      in_i,
  output logic                                 done_o,
  output rk4qfa_pkg::res_t                     res_o,
  input  logic                                 cfg_we_i,
  input  logic [rk4qfa_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [rk4qfa_pkg::WORD_W-1:0]        cfg_data_i
);
  import rk4qfa_pkg::*;

  localparam int W = WORD_W;
  localparam int PROD_W = 2 * W;
  localparam int MAG_W = PROD_W - FRAC_W;
  localparam logic [PROD_W-1:0] RND_C = PROD_W'(64'd1) << (FRAC_W - 1);

  st_e state_q, state_d;
  logic [PC_W-1:0] pc_q, pc_d;
  logic [STEP_COUNT_WIDTH-1:0] steps_q, steps_d;
  logic clip_q;

  logic [STEP_COUNT_WIDTH-1:0] step_count_q;
  logic [W-2:0] step_size_q;
  logic signed [W-1:0] coeff_a_q;

  logic signed [W-1:0] x1_q, x2_q, e1_q, e2_q, f1_q, f2_q, t_q, s_q;
  logic signed [W-1:0] k_q [8];

  logic [PROD_W-1:0] prod_q;
  logic mneg_q;
  src_e mdst_q;

  uop_t uop;
  logic signed [W-1:0] bank [2**$bits(src_e)];
  logic signed [W-1:0] op_a, op_b;

  logic wr_en;
  src_e wr_dst;
  logic signed [W-1:0] wr_val;
  logic wr_clip;

  logic accept;
  logic last_step;

  // ALU values
  logic signed [W:0] sum;
  logic signed [W-1:0] add_val, neg_val, mul_val;
  logic add_ovf, neg_ovf, mul_ovf;
  logic [W-1:0] ua, ub;
  logic [PROD_W-1:0] rnd;
  logic [MAG_W-1:0] magf, lim;

  assign accept = start && (state_q == ST_IDLE);
  assign uop = uop_at(pc_q);
  assign last_step = (steps_q + STEP_COUNT_WIDTH'(1)) == step_count_q;

  always_comb begin
    bank = '{default: '0};
    bank[SRC_X1] = x1_q;
    bank[SRC_X2] = x2_q;
    bank[SRC_E1] = e1_q;
    bank[SRC_E2] = e2_q;
    bank[SRC_F1] = f1_q;
    bank[SRC_F2] = f2_q;
    bank[SRC_T] = t_q;
    bank[SRC_S] = s_q;
    bank[SRC_K0] = k_q[0];
    bank[SRC_K1] = k_q[1];
    bank[SRC_K2] = k_q[2];
    bank[SRC_K3] = k_q[3];
    bank[SRC_K4] = k_q[4];
    bank[SRC_K5] = k_q[5];
    bank[SRC_K6] = k_q[6];
    bank[SRC_K7] = k_q[7];
    bank[SRC_HALF] = HALF_C;
    bank[SRC_SIXTH] = SIXTH_C;
    bank[SRC_DT] = {1'b0, step_size_q};
    bank[SRC_A] = coeff_a_q;
  end

  assign op_a = bank[uop.a];
  assign op_b = bank[uop.b];

  // saturating add and negate
  assign sum = {op_a[W-1], op_a} + {op_b[W-1], op_b};
  assign add_ovf = sum[W] ^ sum[W-1];
  assign add_val = add_ovf ? (sum[W] ? WORD_MIN : WORD_MAX) : sum[W-1:0];
  assign neg_ovf = (op_a == WORD_MIN);
  assign neg_val = neg_ovf ? WORD_MAX : -op_a;

  // multiply magnitudes; the product is rounded and clipped in the following cycle
  assign ua = op_a[W-1] ? W'(-op_a) : W'(op_a);
  assign ub = op_b[W-1] ? W'(-op_b) : W'(op_b);

  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(ua) * PROD_W'(ub);
    mneg_q <= op_a[W-1] ^ op_b[W-1];
    mdst_q <= uop.dst;
  end

  assign rnd = prod_q + RND_C;
  assign magf = rnd[PROD_W-1:FRAC_W];
  assign lim = MAG_W'(WORD_MAX_U[W-1:0]) + MAG_W'(mneg_q);
  assign mul_ovf = magf > lim;
  assign mul_val = mul_ovf ? (mneg_q ? WORD_MIN : WORD_MAX)
                           : (mneg_q ? -magf[W-1:0] : magf[W-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pc_q <= '0;
      steps_q <= '0;
      clip_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pc_q <= pc_d;
      steps_q <= steps_d;
      if (accept) begin
        clip_q <= 1'b0;
      end else if (wr_en && wr_clip) begin
        clip_q <= 1'b1;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    pc_d = pc_q;
    steps_d = steps_q;
    wr_en = 1'b0;
    wr_dst = uop.dst;
    wr_val = add_val;
    wr_clip = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          pc_d = '0;
          steps_d = '0;
          state_d = (step_count_q == '0) ? ST_DONE : ST_EXEC;
        end
      end
      ST_EXEC, ST_MULW: begin
        if (state_q == ST_EXEC && uop.op == OP_MUL) begin
          state_d = ST_MULW;
        end else begin
          wr_en = 1'b1;
          if (state_q == ST_MULW) begin
            wr_dst = mdst_q;
            wr_val = mul_val;
            wr_clip = mul_ovf;
          end else if (uop.op == OP_NEG) begin
            wr_val = neg_val;
            wr_clip = neg_ovf;
          end else begin
            wr_val = add_val;
            wr_clip = add_ovf;
          end
          state_d = ST_EXEC;
          if (pc_q == LAST_PC) begin
            pc_d = '0;
            if (last_step) begin
              state_d = ST_DONE;
            end else begin
              steps_d = steps_q + STEP_COUNT_WIDTH'(1);
            end
          end else begin
            pc_d = pc_q + PC_W'(1);
          end
        end
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x1_q <= in_i.x1_start;
      x2_q <= in_i.x2_start;
    end else if (wr_en) begin
      case (wr_dst)
        SRC_X1: x1_q <= wr_val;
        SRC_X2: x2_q <= wr_val;
        SRC_E1: e1_q <= wr_val;
        SRC_E2: e2_q <= wr_val;
        SRC_F1: f1_q <= wr_val;
        SRC_F2: f2_q <= wr_val;
        SRC_T: t_q <= wr_val;
        SRC_S: s_q <= wr_val;
        SRC_K0: k_q[0] <= wr_val;
        SRC_K1: k_q[1] <= wr_val;
        SRC_K2: k_q[2] <= wr_val;
        SRC_K3: k_q[3] <= wr_val;
        SRC_K4: k_q[4] <= wr_val;
        SRC_K5: k_q[5] <= wr_val;
        SRC_K6: k_q[6] <= wr_val;
        SRC_K7: k_q[7] <= wr_val;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_count_q <= STEP_COUNT_WIDTH'(STEP_COUNT_RST);
      step_size_q <= (W-1)'(STEP_SIZE_RST);
      coeff_a_q <= W'(COEFF_A_RST);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_STEP_COUNT: step_count_q <= cfg_data_i[STEP_COUNT_WIDTH-1:0];
        CFG_STEP_SIZE: step_size_q <= cfg_data_i[W-2:0];
        CFG_COEFF_A: coeff_a_q <= cfg_data_i[W-1:0];
        default: ;
      endcase
    end
  end

  assign busy = (state_q != ST_IDLE);
  assign done_o = (state_q == ST_DONE);
  assign res_o.x1_end = x1_q;
  assign res_o.x2_end = x2_q;
  assign res_o.saturated = clip_q;

  a_done_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("request taken but block not busy");

  a_mul_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC && uop.op == OP_MUL) |=> (state_q == ST_MULW))
    else $error("multiply issued without writeback cycle");

  a_mulw_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MULW) |-> ($past(state_q) == ST_EXEC))
    else $error("multiply writeback without issue");

  a_done_pc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (pc_q == '0))
    else $error("result shown in mid step");

endmodule
